[design/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants, initial hash values and round functions
// for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

	// Input transaction kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// Block geometry and padding
	localparam logic [5:0] LAST_BYTE_IDX = 6'd63;
	localparam logic [5:0] LAST_ROUND    = 6'd63;
	localparam logic [2:0] LAST_WORD_IDX = 3'd7;
	localparam logic [7:0] PAD_MARK      = 8'h80;
	localparam logic [2:0] LEN_ROW       = 3'b111;   // bytes 56..63 of a block

	// Initial hash values H0..H7
	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_PREP,
		ST_ROUND,
		ST_UPDATE,
		ST_OUT
	} sha_state_t;

	// Controls toward the message window
	typedef struct packed {
		logic       byte_we;
		logic       word_done;
		logic [7:0] wr_byte;
		logic       round_shift;
	} sha_sched_ctl_t;

	// Controls toward the round core
	typedef struct packed {
		logic       init;
		logic       round;
		logic [5:0] rnd;
		logic       update;
		logic       reinit;
	} sha_core_ctl_t;

	// Round constants
	function automatic logic [31:0] sha256_k(input logic [5:0] idx);
		logic [31:0] k;
		case (idx)
			6'd0:  k = 32'h428a2f98;
			6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;
			6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;
			6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;
			6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;
			6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;
			6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;
			6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;
			6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;
			6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;
			6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;
			6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;
			6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;
			6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;
			6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;
			6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;
			6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;
			6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;
			6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;
			6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;
			6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;
			6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;
			6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;
			6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;
			6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	// Message schedule sigmas
	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	// Compression sigmas
	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

endpackage

[design/sha256_stream_hasher.sv]
// Input: bytes are accepted only while idle; the 64th byte of a block starts
// the working-variable load, 64 rounds on the shared round core and the hash
// update, and no new byte is taken until the block is folded in.
// Finish: padding bytes one per cycle up to the block end, then one or two
// blocks, then 8 digest transactions at one per cycle while out_ready holds.
// Reset: asynchronous, hash words to the initial values, counters cleared.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-stream SHA-256 with padding and an eight-word digest output.
// ----------------------------------------------------------------------------
module sha256_stream_hasher import sha256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha_sched_ctl_t sched_ctl;
	sha_core_ctl_t  core_ctl;
	logic [31:0]    w0;
	logic [31:0]    w1;

	// Sequencer
	sha256_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.word_index (word_index),
		.last_word  (last_word),
		.sched_ctl  (sched_ctl),
		.core_ctl   (core_ctl)
	);

	// Message window and schedule
	sha256_sched u_sched (
		.clk       (clk),
		.sched_ctl (sched_ctl),
		.w0        (w0),
		.w1        (w1)
	);

	// Round core and hash state
	sha256_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.core_ctl    (core_ctl),
		.w0          (w0),
		.w1          (w1),
		.word_index  (word_index),
		.digest_word (digest_word)
	);

endmodule

[design/sha256_ctrl.sv]
// ----------------------------------------------------------------------------
// SHA-256 sequencer
// Input handshake, byte fill count, padding byte generation, round counter,
// message bit length and digest word output sequencing.
// ----------------------------------------------------------------------------
module sha256_ctrl import sha256_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           kind,
	input  logic [7:0]     data_byte,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     word_index,
	output logic           last_word,
	output sha_sched_ctl_t sched_ctl,
	output sha_core_ctl_t  core_ctl
);

	sha_state_t  state_q, state_d;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic [63:0] bitlen_q;
	logic        mark_q;       // next pad byte is the 0x80 marker
	logic        extra_q;      // marker spilled into the length row: one more block
	logic        last_blk_q;   // block in flight carries the length

	logic        in_acc;
	logic        data_acc;
	logic        fin_acc;
	logic        out_acc;
	logic        pad_we;
	logic [7:0]  pad_byte;

	assign in_acc   = in_valid && in_ready;
	assign data_acc = in_acc && (kind == KIND_DATA);
	assign fin_acc  = in_acc && (kind == KIND_FINISH);
	assign out_acc  = out_valid && out_ready;
	assign pad_we   = (state_q == ST_PAD);

	// Padding byte: marker, zero fill, or big-endian length in the last row
	always_comb begin
		if (mark_q) begin
			pad_byte = PAD_MARK;
		end else if ((fill_q[5:3] == LEN_ROW) && !extra_q) begin
			pad_byte = bitlen_q[{~fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (kind == KIND_FINISH) begin
						state_d = ST_PAD;
					end else if (fill_q == LAST_BYTE_IDX) begin
						state_d = ST_PREP;
					end
				end
			end
			ST_PAD: begin
				if (fill_q == LAST_BYTE_IDX) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (rnd_q == LAST_ROUND) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (last_blk_q) begin
					state_d = ST_OUT;
				end else if (extra_q || !mark_q && fill_q != 6'd0) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_ready && (oidx_q == LAST_WORD_IDX)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		in_ready              = (state_q == ST_IDLE);
		out_valid             = (state_q == ST_OUT);
		word_index            = oidx_q;
		last_word             = (oidx_q == LAST_WORD_IDX);
		sched_ctl.byte_we     = data_acc || pad_we;
		sched_ctl.word_done   = (fill_q[1:0] == 2'b11);
		sched_ctl.wr_byte     = pad_we ? pad_byte : data_byte;
		sched_ctl.round_shift = (state_q == ST_ROUND);
		core_ctl.init         = (state_q == ST_PREP);
		core_ctl.round        = (state_q == ST_ROUND);
		core_ctl.rnd          = rnd_q;
		core_ctl.update       = (state_q == ST_UPDATE);
		core_ctl.reinit       = out_acc && (oidx_q == LAST_WORD_IDX);
	end

	// State and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			rnd_q      <= '0;
			oidx_q     <= '0;
			bitlen_q   <= '0;
			mark_q     <= 1'b0;
			extra_q    <= 1'b0;
			last_blk_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (sched_ctl.byte_we) begin
				fill_q <= fill_q + 6'd1;
			end

			if (data_acc) begin
				bitlen_q <= bitlen_q + 64'd8;
			end

			if (fin_acc) begin
				mark_q     <= 1'b1;
				extra_q    <= 1'b0;
				last_blk_q <= 1'b0;
			end

			if (pad_we) begin
				mark_q <= 1'b0;
				if (fill_q == LAST_BYTE_IDX) begin
					// marker in the last byte also needs a length block
					extra_q    <= mark_q || extra_q;
					last_blk_q <= !mark_q && !extra_q;
				end else if (mark_q && (fill_q[5:3] == LEN_ROW)) begin
					extra_q <= 1'b1;
				end
			end

			// extra block is on its way once the first one is folded in
			if (state_q == ST_UPDATE) begin
				extra_q <= 1'b0;
			end

			if (state_q == ST_PREP) begin
				rnd_q <= '0;
			end else if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end

			if (out_acc) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == LAST_WORD_IDX) begin
					bitlen_q   <= '0;
					last_blk_q <= 1'b0;
				end
			end
		end
	end

endmodule

[design/sha256_sched.sv]
// ----------------------------------------------------------------------------
// SHA-256 message window
// Packs bytes into big-endian words, shifts them into a 16-word window and
// expands the message schedule one word per round.
// ----------------------------------------------------------------------------
module sha256_sched import sha256_pkg::*; (
	input  logic           clk,
	input  sha_sched_ctl_t sched_ctl,
	output logic [31:0]    w0,
	output logic [31:0]    w1
);

	logic [23:0] acc_q;          // first three bytes of the current word
	logic [31:0] win_q [16];     // window W[r] .. W[r+15], oldest at 0
	logic [31:0] new_word;
	logic        win_shift;

	// Word entering the window: a packed message word or the next schedule word
	always_comb begin
		if (sched_ctl.round_shift) begin
			new_word = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
		end else begin
			new_word = {acc_q, sched_ctl.wr_byte};
		end
	end

	assign win_shift = sched_ctl.round_shift || (sched_ctl.byte_we && sched_ctl.word_done);

	// Byte packing
	always_ff @(posedge clk) begin
		if (sched_ctl.byte_we && !sched_ctl.word_done) begin
			acc_q <= {acc_q[15:0], sched_ctl.wr_byte};
		end
	end

	// Window shift line
	always_ff @(posedge clk) begin
		if (win_shift) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= new_word;
		end
	end

	assign w0 = win_q[0];
	assign w1 = win_q[1];

endmodule

[design/sha256_core.sv]
// ----------------------------------------------------------------------------
// SHA-256 round core
// Working variables a..h, one compression round per cycle, hash words with
// the end-of-block addition and digest word selection.
// ----------------------------------------------------------------------------
module sha256_core import sha256_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  sha_core_ctl_t core_ctl,
	input  logic [31:0]   w0,
	input  logic [31:0]   w1,
	input  logic [2:0]    word_index,
	output logic [31:0]   digest_word
);

	logic [31:0] hash_q [8];
	logic [31:0] v_q [8];        // a..h
	logic [31:0] hkw_q;          // h + K[r] + W[r], registered ahead of the round that uses it
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] hkw_next;

	// Round function
	always_comb begin
		ch       = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj      = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1       = hkw_q + big_sigma1(v_q[4]) + ch;
		t2       = big_sigma0(v_q[0]) + maj;
		hkw_next = v_q[6] + sha256_k(core_ctl.rnd + 6'd1) + w1;
	end

	// Working variables
	always_ff @(posedge clk) begin
		if (core_ctl.init) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= hash_q[i];
			end
			hkw_q <= hash_q[7] + sha256_k(6'd0) + w0;
		end else if (core_ctl.round) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
			hkw_q  <= hkw_next;
		end
	end

	// Hash words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= SHA_IV[i];
			end
		end else if (core_ctl.reinit) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= SHA_IV[i];
			end
		end else if (core_ctl.update) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + v_q[i];
			end
		end
	end

	assign digest_word = hash_q[word_index];

endmodule

[test/sha256_digest_tracker_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 digest tracker
// Scoreboard for the stream hasher. It keeps its own SHA-256 state, turns
// each accepted input transaction into expected digest words, and checks the
// digest transactions in order against them.
// ----------------------------------------------------------------------------
package sha256_digest_tracker_pkg;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_entry_t;

	class sha256_digest_tracker;
		localparam logic [7:0] PAD_BYTE      = 8'h80;
		localparam int         BLOCK_BYTES   = 64;
		localparam int         LENGTH_OFFSET = 56;

		logic [31:0]   round_k [64];
		logic [31:0]   initial_hash [8];
		logic [31:0]   hash_state [8];
		logic [63:0]   message_bits;
		logic [7:0]    block_buf [64];
		int            fill;
		digest_entry_t expected_words [$];
		int            failures;

		function new();
			round_k = '{
				32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
				32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
				32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
				32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
				32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
				32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
				32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
				32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
				32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
				32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
				32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
				32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
				32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
				32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
				32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
				32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
			};
			initial_hash = '{
				32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
				32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
			};
			failures = 0;
			restart();
		endfunction

		// Fresh message: initial hash, empty buffer, zero length
		function void restart();
			hash_state   = initial_hash;
			message_bits = '0;
			fill         = 0;
		endfunction

		function logic [31:0] rotr(input logic [31:0] x, input int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		// 64-round compression of the buffered block into the hash state
		function void compress_block();
			logic [31:0] w [64];
			logic [31:0] a, b, c, d, e, f, g, h;
			logic [31:0] s0, s1, t1, t2;
			for (int r = 0; r < 16; r++)
				w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
			for (int r = 16; r < 64; r++) begin
				s0   = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
				s1   = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
				w[r] = s1 + w[r-7] + s0 + w[r-16];
			end
			a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
			e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
			for (int r = 0; r < 64; r++) begin
				t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
					+ round_k[r] + w[r];
				t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
				h = g; g = f; f = e; e = d + t1;
				d = c; c = b; b = a; a = t1 + t2;
			end
			hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
			hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
		endfunction

		// Append one byte; a full block is compressed right away
		function void push_byte(input logic [7:0] value);
			block_buf[fill] = value;
			fill++;
			if (fill == BLOCK_BYTES) begin
				compress_block();
				fill = 0;
			end
		endfunction

		// Accepted input transaction: data byte or finish with padding
		function void note_item(input logic item_kind, input logic [7:0] item_byte);
			digest_entry_t entry;
			if (item_kind == sha256_pkg::KIND_DATA) begin
				push_byte(item_byte);
				message_bits += 64'd8;
			end else begin
				// mark byte, zero fill (spills into an extra block past 56), length
				push_byte(PAD_BYTE);
				while (fill != LENGTH_OFFSET)
					push_byte(8'h00);
				for (int j = 7; j >= 0; j--)
					push_byte(message_bits[8*j +: 8]);
				for (int j = 0; j < 8; j++) begin
					entry.word  = hash_state[j];
					entry.index = 3'(j);
					entry.last  = (j == 7);
					expected_words.push_back(entry);
				end
				restart();
			end
		endfunction

		// Accepted digest transaction against the oldest expected word
		function void check_word(input logic [31:0] word, input logic [2:0] index,
				input logic last);
			digest_entry_t exp_entry;
			if (expected_words.size() == 0) begin
				$error("unexpected digest transaction: word %h index %0d", word, index);
				failures++;
				return;
			end
			exp_entry = expected_words.pop_front();
			if (word !== exp_entry.word) begin
				$error("digest_word: expected %h, actual %h", exp_entry.word, word);
				failures++;
			end
			if (index !== exp_entry.index) begin
				$error("word_index: expected %0d, actual %0d", exp_entry.index, index);
				failures++;
			end
			if (last !== exp_entry.last) begin
				$error("last_word: expected %0b, actual %0b", exp_entry.last, last);
				failures++;
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

endpackage

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte messages and finish transactions through the valid/ready input,
// predicts every digest word with its own SHA-256 model and checks the
// output stream. Covers the empty message, padding that spills into an extra
// block, exact block fills, and random messages under three idling patterns.
// ----------------------------------------------------------------------------
module testbench;
	import sha256_pkg::*;
	import sha256_digest_tracker_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 9;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int DRAIN_CYCLES = 200;
	localparam int PHASE_ITEMS  = 60;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic        kind      = KIND_DATA;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int unsigned cycle_count    = 0;

	sha256_digest_tracker digest_model = new();

	sha256_stream_hasher u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	// Clock
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Receiver back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Monitor: results checked before a same-edge input is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				digest_model.check_word(digest_word, word_index, last_word);
			if (in_valid && in_ready)
				digest_model.note_item(kind, data_byte);
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** sha256_stream_hasher: FAILED **");
			$finish;
		end
	end

	// One input transaction; entered and left at a falling edge
	task automatic send_item(input logic item_kind, input logic [7:0] item_byte);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid  = 1'b1;
		kind      = item_kind;
		data_byte = item_byte;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Random bytes followed by a finish with a don't-care byte
	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_item(KIND_DATA, 8'($urandom_range(0, 255)));
		send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// Hold the input until every expected digest word has come out
	task automatic wait_drained();
		in_valid = 1'b0;
		while (digest_model.pending() != 0)
			@(negedge clk);
	endtask

	// Random messages under one idling pattern, opened by a padding boundary
	task automatic run_phase(input int idle_pct, input int stall_pct, input int boundary_len);
		int sent;
		int len;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		send_message(boundary_len);
		sent = boundary_len + 1;
		while (sent < PHASE_ITEMS) begin
			len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 30);
			send_message(len);
			sent += len + 1;
		end
		wait_drained();
	endtask

	// Stimulus
	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty message, finish byte ignored
		send_item(KIND_FINISH, 8'hff);
		// "abc"
		send_item(KIND_DATA, 8'h61);
		send_item(KIND_DATA, 8'h62);
		send_item(KIND_DATA, 8'h63);
		send_item(KIND_FINISH, 8'h00);
		// byte extremes
		send_item(KIND_DATA, 8'h00);
		send_item(KIND_DATA, 8'hff);
		send_item(KIND_DATA, 8'h80);
		send_item(KIND_DATA, 8'h7f);
		send_item(KIND_DATA, 8'h01);
		send_item(KIND_FINISH, 8'h55);
		// finish right after a finish: empty message after re-init
		send_item(KIND_FINISH, 8'haa);
		wait_drained();

		// 55 bytes fit one block, 56 need an extra one, 64 fill one exactly
		run_phase(11, 82, 55);
		run_phase(82, 11, 56);
		run_phase(0, 0, 64);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (digest_model.failures == 0)
			$display("** sha256_stream_hasher: PASSED **");
		else
			$display("** sha256_stream_hasher: FAILED **");
		$finish;
	end

endmodule
